[sv/assert_macros.svh]
// Assertion macros used by the top level of the core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication violated");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

`endif

[sv/mmp_pkg.sv]
// Shared constants and types of the modular matrix power core.
package mmp_pkg;

    localparam int MAX_DIM   = 8;
    localparam int CELLS     = MAX_DIM * MAX_DIM;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int DIM_W     = $clog2(MAX_DIM + 1);
    localparam int CNT_W     = $clog2(CELLS + 1);
    localparam int MOD_W     = 31;
    localparam int ELEM_W    = 32;
    localparam int EXP_W     = 64;
    localparam int DIM_CFG_W = 4;
    localparam int N_CELLS   = ELEM_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMENSION = 1'b1;

    localparam logic [MOD_W-1:0]     MOD_RESET = 31'd1000000007;
    localparam logic [DIM_CFG_W-1:0] DIM_RESET = 4'd2;

    typedef struct packed {
        logic              first;
        logic              last;
        logic [ADDR_W-1:0] addr;
    } t_tag;

    // one multiply-reduce job moving down the cell chain
    typedef struct packed {
        logic              valid;
        logic [ELEM_W-1:0] a;
        logic [MOD_W-1:0]  b;
        logic [MOD_W-1:0]  acc;
        t_tag              tag;
    } t_job;

    // finished, accumulated entry leaving the chain
    typedef struct packed {
        logic              valid;
        logic [ADDR_W-1:0] addr;
        logic [MOD_W-1:0]  data;
    } t_wr;

endpackage

[sv/mmp_cell.sv]
// One cell of the modular multiply chain: acc = 2*acc + bit*b mod m.
module mmp_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [mmp_pkg::MOD_W-1:0] i_mod,
    input  mmp_pkg::t_job             i_job,
    output mmp_pkg::t_job             o_job
);
    import mmp_pkg::*;

    logic [MOD_W:0]    dbl;
    logic [MOD_W:0]    dbl_red;
    logic [MOD_W:0]    sum;
    logic [MOD_W:0]    sum_red;
    logic              r_valid;
    logic [ELEM_W-1:0] r_a;
    logic [MOD_W-1:0]  r_b;
    logic [MOD_W-1:0]  r_acc;
    t_tag              r_tag;

    // b <= m and acc < m keep each partial below 2m
    always_comb begin
        dbl     = {i_job.acc, 1'b0};
        dbl_red = (dbl >= {1'b0, i_mod}) ? dbl - {1'b0, i_mod} : dbl;
        sum     = dbl_red + (i_job.a[ELEM_W-1] ? {1'b0, i_job.b} : '0);
        sum_red = (sum >= {1'b0, i_mod}) ? sum - {1'b0, i_mod} : sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_job.valid;
        end
        r_a   <= {i_job.a[ELEM_W-2:0], 1'b0};
        r_b   <= i_job.b;
        r_acc <= sum_red[MOD_W-1:0];
        r_tag <= i_job.tag;
    end

    assign o_job.valid = r_valid;
    assign o_job.a     = r_a;
    assign o_job.b     = r_b;
    assign o_job.acc   = r_acc;
    assign o_job.tag   = r_tag;

endmodule

[sv/mmp_chain.sv]
// Row of multiply cells with the dot-product accumulator at its tail.
module mmp_chain (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [mmp_pkg::MOD_W-1:0] i_mod,
    input  mmp_pkg::t_job             i_job,
    output mmp_pkg::t_wr              o_wr
);
    import mmp_pkg::*;

    t_job             stage [N_CELLS+1];
    t_job             tail;
    logic [MOD_W-1:0] r_sum;
    logic [MOD_W:0]   s;
    logic [MOD_W-1:0] w;

    assign stage[0] = i_job;

    for (genvar gi = 0; gi < N_CELLS; gi++) begin : g_cell
        mmp_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_mod   (i_mod),
            .i_job   (stage[gi]),
            .o_job   (stage[gi+1])
        );
    end

    assign tail = stage[N_CELLS];

    always_comb begin
        s = {1'b0, r_sum} + {1'b0, tail.acc};
        if (tail.tag.first) begin
            w = tail.acc;
        end else if (s >= {1'b0, i_mod}) begin
            w = MOD_W'(s - {1'b0, i_mod});
        end else begin
            w = s[MOD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tail.valid) begin
            r_sum <= w;
        end
    end

    assign o_wr.valid = tail.valid & tail.tag.last;
    assign o_wr.addr  = tail.tag.addr;
    assign o_wr.data  = w;

endmodule

[sv/mmp_ctrl.sv]
// Sequencer and matrix memories: load, normalize, square-and-multiply, readout.
module mmp_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [mmp_pkg::MOD_W-1:0]  i_mod,
    input  logic [mmp_pkg::DIM_W-1:0]  i_dim,
    input  logic                       i_accept,
    input  logic [mmp_pkg::ELEM_W-1:0] i_element,
    input  logic [mmp_pkg::EXP_W-1:0]  i_exponent,
    input  logic                       i_last,
    input  mmp_pkg::t_wr               i_wr,
    output mmp_pkg::t_job              o_job,
    output logic                       o_busy,
    output logic                       o_strobe,
    output logic [mmp_pkg::MOD_W-1:0]  o_entry,
    output logic                       o_last_entry
);
    import mmp_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOAD = 6'b000010,
        S_NORM = 6'b000100,
        S_PROD = 6'b001000,
        S_COPY = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        SRC_IN,
        SRC_BASE,
        SRC_RES,
        SRC_SQ
    } t_src;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_pos;
    logic                r_last;
    logic                r_neg;
    logic [EXP_W-1:0]    r_exp;
    logic                r_sel;          // 0: result*square, 1: square*square
    logic [IDX_W-1:0]    r_i, r_j, r_k;
    logic                r_issue_done;
    logic [CNT_W-1:0]    r_wr_cnt;
    logic                r_iss_valid;
    t_src                r_iss_src;
    logic [ELEM_W-1:0]   r_iss_mag;
    t_tag                r_iss_tag;
    logic                r_cp_valid;
    logic [ADDR_W-1:0]   r_cp_addr;
    logic                r_out_valid;
    logic                r_out_last;

    logic [MOD_W-1:0]    r_base_mem [CELLS];
    logic [MOD_W-1:0]    r_sq_mem   [CELLS];
    logic [MOD_W-1:0]    r_res_mem  [CELLS];
    logic [MOD_W-1:0]    r_prod_mem [CELLS];
    logic [MOD_W-1:0]    r_rd_b, r_rd_s0, r_rd_s1, r_rd_r, r_rd_p;

    logic [2*DIM_W-1:0]       dim_sq;
    logic [CNT_W-1:0]         total;
    logic [IDX_W-1:0]         dm1;
    logic [IDX_W-1:0]         kmax;
    logic [IDX_W+DIM_W-1:0]   i_base, k_base;
    logic [IDX_W+DIM_W-1:0]   ij_full, x_full, y_full;
    logic [ADDR_W-1:0]        addr_ij, x_addr, y_addr, r_addr;
    logic                     issuing;
    logic                     at_end;
    logic                     wr_done;
    logic [MOD_W-1:0]         b_wdata;
    logic [MOD_W-1:0]         ident;

    always_comb begin
        dim_sq  = i_dim * i_dim;
        total   = dim_sq[CNT_W-1:0];
        dm1     = IDX_W'(i_dim - 1'b1);
        kmax    = (r_state == S_PROD) ? dm1 : '0;
        i_base  = r_i * i_dim;
        k_base  = r_k * i_dim;
        ij_full = i_base + (IDX_W+DIM_W)'(r_j);
        x_full  = i_base + (IDX_W+DIM_W)'(r_k);
        y_full  = k_base + (IDX_W+DIM_W)'(r_j);
        addr_ij = ij_full[ADDR_W-1:0];
        x_addr  = x_full[ADDR_W-1:0];
        y_addr  = y_full[ADDR_W-1:0];
        r_addr  = (r_state == S_PROD) ? x_addr : addr_ij;
        issuing = !r_issue_done && (r_state == S_NORM || r_state == S_PROD ||
                                    r_state == S_COPY || r_state == S_OUT);
        at_end  = (r_k == kmax) && (r_j == dm1) && (r_i == dm1);
        wr_done = r_issue_done && (r_wr_cnt == total);
        ident   = (r_i == r_j && i_mod != MOD_W'(1)) ? MOD_W'(1) : '0;
        // negative elements were reduced by magnitude
        b_wdata = (r_neg && i_wr.data != '0) ? i_mod - i_wr.data : i_wr.data;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    if (r_pos < total) begin
                        n_state = S_LOAD;
                    end else if (i_last) begin
                        n_state = S_NORM;
                    end
                end
            end
            S_LOAD: begin
                if (i_wr.valid) begin
                    n_state = r_last ? S_NORM : S_IDLE;
                end
            end
            S_NORM: begin
                if (wr_done) begin
                    n_state = (r_exp == '0) ? S_OUT : S_PROD;
                end
            end
            S_PROD: begin
                if (wr_done) begin
                    n_state = S_COPY;
                end
            end
            S_COPY: begin
                if (r_issue_done && !r_cp_valid) begin
                    n_state = (!r_sel && r_exp[EXP_W-1:1] == '0) ? S_OUT : S_PROD;
                end
            end
            S_OUT: begin
                if (r_issue_done) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pos        <= '0;
            r_exp        <= '0;
            r_last       <= 1'b0;
            r_sel        <= 1'b0;
            r_i          <= '0;
            r_j          <= '0;
            r_k          <= '0;
            r_issue_done <= 1'b0;
            r_wr_cnt     <= '0;
            r_iss_valid  <= 1'b0;
            r_cp_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_last   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_iss_valid <= 1'b0;
            r_cp_valid  <= 1'b0;
            r_out_valid <= 1'b0;

            if (n_state != r_state) begin
                r_i          <= '0;
                r_j          <= '0;
                r_k          <= '0;
                r_issue_done <= 1'b0;
                r_wr_cnt     <= '0;
            end else begin
                if (issuing) begin
                    if (r_k != kmax) begin
                        r_k <= r_k + 1'b1;
                    end else begin
                        r_k <= '0;
                        if (r_j != dm1) begin
                            r_j <= r_j + 1'b1;
                        end else begin
                            r_j <= '0;
                            if (r_i != dm1) begin
                                r_i <= r_i + 1'b1;
                            end else begin
                                r_issue_done <= 1'b1;
                            end
                        end
                    end
                end
                if (i_wr.valid) begin
                    r_wr_cnt <= r_wr_cnt + 1'b1;
                end
            end

            case (r_state)
                S_IDLE: begin
                    if (i_accept) begin
                        r_last <= i_last;
                        if (i_last) begin
                            r_exp <= i_exponent;
                        end
                        if (r_pos < total) begin
                            r_iss_valid     <= 1'b1;
                            r_iss_src       <= SRC_IN;
                            r_iss_mag       <= i_element[ELEM_W-1] ? -i_element : i_element;
                            r_iss_tag.first <= 1'b1;
                            r_iss_tag.last  <= 1'b1;
                            r_iss_tag.addr  <= r_pos[ADDR_W-1:0];
                            r_neg           <= i_element[ELEM_W-1];
                            r_pos           <= r_pos + 1'b1;
                        end else if (i_last) begin
                            r_pos <= '0;
                        end
                    end
                end
                S_LOAD: begin
                    if (i_wr.valid && r_last) begin
                        r_pos <= '0;
                    end
                end
                S_NORM: begin
                    if (issuing) begin
                        r_iss_valid     <= 1'b1;
                        r_iss_src       <= SRC_BASE;
                        r_iss_tag.first <= 1'b1;
                        r_iss_tag.last  <= 1'b1;
                        r_iss_tag.addr  <= addr_ij;
                    end
                    if (wr_done) begin
                        r_sel <= ~r_exp[0];
                    end
                end
                S_PROD: begin
                    if (issuing) begin
                        r_iss_valid     <= 1'b1;
                        r_iss_src       <= r_sel ? SRC_SQ : SRC_RES;
                        r_iss_tag.first <= (r_k == '0);
                        r_iss_tag.last  <= (r_k == kmax);
                        r_iss_tag.addr  <= addr_ij;
                    end
                end
                S_COPY: begin
                    if (issuing) begin
                        r_cp_valid <= 1'b1;
                        r_cp_addr  <= addr_ij;
                    end
                    if (r_issue_done && !r_cp_valid) begin
                        if (!r_sel) begin
                            r_sel <= 1'b1;
                            if (r_exp[EXP_W-1:1] == '0) begin
                                r_exp <= '0;
                            end
                        end else begin
                            r_sel <= ~r_exp[1];
                            r_exp <= r_exp >> 1;
                        end
                    end
                end
                S_OUT: begin
                    if (issuing) begin
                        r_out_valid <= 1'b1;
                        r_out_last  <= at_end;
                    end
                end
                default: ;
            endcase
        end
    end

    // matrix memories, registered reads
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD && i_wr.valid) begin
            r_base_mem[i_wr.addr] <= b_wdata;
        end
        r_rd_b <= r_base_mem[addr_ij];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_NORM && i_wr.valid) begin
            r_sq_mem[i_wr.addr] <= i_wr.data;
        end else if (r_state == S_COPY && r_cp_valid && r_sel) begin
            r_sq_mem[r_cp_addr] <= r_rd_p;
        end
        r_rd_s0 <= r_sq_mem[x_addr];
        r_rd_s1 <= r_sq_mem[y_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_NORM && issuing) begin
            r_res_mem[addr_ij] <= ident;
        end else if (r_state == S_COPY && r_cp_valid && !r_sel) begin
            r_res_mem[r_cp_addr] <= r_rd_p;
        end
        r_rd_r <= r_res_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PROD && i_wr.valid) begin
            r_prod_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd_p <= r_prod_mem[addr_ij];
    end

    always_comb begin
        o_job.valid = r_iss_valid;
        o_job.acc   = '0;
        o_job.tag   = r_iss_tag;
        case (r_iss_src)
            SRC_IN: begin
                o_job.a = r_iss_mag;
                o_job.b = MOD_W'(1);
            end
            SRC_BASE: begin
                o_job.a = {1'b0, r_rd_b};
                o_job.b = MOD_W'(1);
            end
            SRC_RES: begin
                o_job.a = {1'b0, r_rd_r};
                o_job.b = r_rd_s1;
            end
            SRC_SQ: begin
                o_job.a = {1'b0, r_rd_s0};
                o_job.b = r_rd_s1;
            end
            default: begin
                o_job.a = '0;
                o_job.b = '0;
            end
        endcase
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_strobe     = r_out_valid;
    assign o_entry      = r_rd_r;
    assign o_last_entry = r_out_last;

endmodule

[sv/modular_matrix_power_core.sv]
// Top level of the modular matrix power core.
// Raises an n x n matrix (n = dimension, 1..8) to a 64-bit power modulo a 31-bit
// modulus by square-and-multiply. Each element transfer keeps busy high while the
// element is reduced through the 32-cell multiply chain. An element that arrives
// after the matrix is full and carries no last mark is dropped without raising busy.
// After the last element, the matrix is normalized, then each matrix product runs
// through the chain, followed by a copy sweep; there are up to two products per exponent
// bit. Results then leave as n*n one-cycle strobes in row-major order; the receiver
// cannot stall them.
// Configuration is accepted only while busy and start are both low.
`include "assert_macros.svh"

module modular_matrix_power_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [mmp_pkg::ELEM_W-1:0] i_element,
    input  logic [mmp_pkg::EXP_W-1:0]      i_exponent,
    input  logic                           i_last_element,
    output logic                           o_strobe,
    output logic [mmp_pkg::MOD_W-1:0]      o_entry,
    output logic                           o_last_entry,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mmp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mmp_pkg::MOD_W-1:0]      i_cfg_data
);
    import mmp_pkg::*;

    logic [MOD_W-1:0]     r_mod;
    logic [DIM_CFG_W-1:0] r_dim;
    logic [MOD_W-1:0]     eff_mod;
    logic [DIM_W-1:0]     eff_dim;
    logic                 accept;
    t_job                 job;
    t_wr                  chain_wr;

    // no register write in the same cycle as an element transfer
    assign o_cfg_ready = ~busy & ~start;
    assign accept      = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= MOD_RESET;
            r_dim <= DIM_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MODULUS:   r_mod <= i_cfg_data;
                CFG_DIMENSION: r_dim <= i_cfg_data[DIM_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // zero modulus acts as one; dimension clamps to 1..MAX_DIM
    always_comb begin
        eff_mod = (r_mod == '0) ? MOD_W'(1) : r_mod;
        if (r_dim == '0) begin
            eff_dim = DIM_W'(1);
        end else if (DIM_W'(r_dim) > DIM_W'(MAX_DIM)) begin
            eff_dim = DIM_W'(MAX_DIM);
        end else begin
            eff_dim = DIM_W'(r_dim);
        end
    end

    mmp_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mod        (eff_mod),
        .i_dim        (eff_dim),
        .i_accept     (accept),
        .i_element    (i_element),
        .i_exponent   (i_exponent),
        .i_last       (i_last_element),
        .i_wr         (chain_wr),
        .o_job        (job),
        .o_busy       (busy),
        .o_strobe     (o_strobe),
        .o_entry      (o_entry),
        .o_last_entry (o_last_entry)
    );

    mmp_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mod   (eff_mod),
        .i_job   (job),
        .o_wr    (chain_wr)
    );

    `ASSERT_IMPLY(a_strobe_busy, i_clk, i_rst_n, o_strobe, busy)
    `ASSERT_IMPLY(a_wr_busy, i_clk, i_rst_n, chain_wr.valid, busy)
    `ASSERT_NEXT(a_last_gap, i_clk, i_rst_n, o_strobe && o_last_entry, !o_strobe)

endmodule

[sim/modular_matrix_power_core_tb.sv]
// Self-checking testbench of the modular matrix power core: directed table, then random loads.
module modular_matrix_power_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mmp_pkg::*;

    typedef logic [CELLS-1:0][MOD_W-1:0] t_mat;

    typedef struct packed {
        logic [MOD_W-1:0] entry;
        logic             last;
    } t_entry;

    typedef struct {
        bit          setcfg;
        int unsigned modv;
        int unsigned dimv;
        logic [31:0] elem;
        logic [63:0] expo;
        bit          last;
        bit          chk;
        int unsigned want;
    } t_plan_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [ELEM_W-1:0]    i_element = '0;
    logic [EXP_W-1:0]     i_exponent = '0;
    logic                 i_last_element = 1'b0;
    logic                 o_strobe;
    logic [MOD_W-1:0]     o_entry;
    logic                 o_last_entry;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_MODULUS;
    logic [MOD_W-1:0]     i_cfg_data = '0;

    modular_matrix_power_core i_dut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor state
    logic [MOD_W-1:0]     mod_reg = MOD_RESET;
    logic [DIM_CFG_W-1:0] dim_reg = DIM_RESET;
    t_mat                 base_cells = '0;
    bit                   loaded [CELLS];
    int                   load_pos = 0;
    t_entry               entries_due [$];
    int                   errors = 0;

    function automatic longint unsigned eff_mod();
        return (mod_reg == 0) ? 64'd1 : 64'(mod_reg);
    endfunction

    function automatic int eff_dim();
        if (dim_reg == 0) return 1;
        if (dim_reg > MAX_DIM) return MAX_DIM;
        return int'(dim_reg);
    endfunction

    function automatic t_mat mat_mul(t_mat x, t_mat y, int n, longint unsigned m);
        t_mat             p;
        longint unsigned  acc;
        p = '0;
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                acc = 0;
                for (int k = 0; k < n; k++)
                    acc = (acc + 64'(x[i*n+k]) * 64'(y[k*n+j])) % m;
                p[i*n+j] = acc[MOD_W-1:0];
            end
        end
        return p;
    endfunction

    // returns 1 when the element was ignored (load already full, no last mark)
    function automatic bit predict_power(logic [31:0] el, logic [63:0] ex, bit lst);
        int              n;
        longint unsigned m;
        longint unsigned r;
        longint unsigned mag;
        logic [63:0]     e;
        t_mat            sq;
        t_mat            acc_m;
        bit              ignored;
        n = eff_dim();
        m = eff_mod();
        if (el[31]) begin
            mag = {32'b0, ~el} + 64'd1;
            r = mag % m;
            r = (r == 0) ? 0 : m - r;
        end else begin
            r = 64'(el) % m;
        end
        ignored = 1'b1;
        if (load_pos < n*n) begin
            base_cells[load_pos] = r[MOD_W-1:0];
            loaded[load_pos] = 1'b1;
            load_pos++;
            ignored = 1'b0;
        end
        if (!lst) return ignored;
        sq = base_cells;
        acc_m = '0;
        for (int i = 0; i < n*n; i++)
            acc_m[i] = MOD_W'(((i / n == i % n) ? 64'd1 : 64'd0) % m);
        e = ex;
        while (e != 0) begin
            if (e[0]) acc_m = mat_mul(acc_m, sq, n, m);
            sq = mat_mul(sq, sq, n, m);
            e >>= 1;
        end
        load_pos = 0;
        for (int i = 0; i < n*n; i++)
            entries_due.push_back('{entry: acc_m[i], last: (i == n*n-1)});
        return 1'b0;
    endfunction

    // results come without back-pressure; values sampled before this edge's updates
    always @(posedge i_clk) begin
        t_entry want;
        if (i_rst_n && o_strobe) begin
            if (entries_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected entry %0d last %0b", o_entry, o_last_entry);
            end else begin
                want = entries_due.pop_front();
                if (want.entry !== o_entry || want.last !== o_last_entry) begin
                    errors++;
                    if (errors <= 10)
                        $display("entry mismatch: expected %0d/%0b got %0d/%0b",
                                 want.entry, want.last, o_entry, o_last_entry);
                end
            end
        end
    end

    task automatic wait_drained();
        while (entries_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // leaves valid high so back-to-back writes need no lowering within a step
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MOD_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_MODULUS) mod_reg = data;
        else dim_reg = data[DIM_CFG_W-1:0];
    endtask

    task automatic set_config(logic [MOD_W-1:0] modv, logic [MOD_W-1:0] dimv);
        start <= 1'b0;
        wait_drained();
        write_reg(CFG_MODULUS, modv);
        write_reg(CFG_DIMENSION, dimv);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_elem(logic [31:0] el, logic [63:0] ex, bit lst, bit calm,
                             output bit ignored);
        if (!calm) begin
            while ($urandom_range(0, 99) < 29) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start          <= 1'b1;
        i_element      <= el;
        i_exponent     <= ex;
        i_last_element <= lst;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        ignored = predict_power(el, ex, lst);
    endtask

    function automatic logic [31:0] pick_elem();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    initial begin
        t_plan_row plan [20];
        bit        ign;
        int        counted;
        int        phase;
        int        n;
        int        total;
        int        cut;
        int        kind;
        int        reps;
        bit        calm;
        bit        big_done;
        bit        ok;
        logic [MOD_W-1:0] modv;
        logic [MOD_W-1:0] dimv;
        logic [63:0]      ex;

        plan = '{
            '{0, 0, 0, 32'd1, 64'd0, 0, 0, 0},
            '{0, 0, 0, 32'd1, 64'd0, 0, 0, 0},
            '{0, 0, 0, 32'd1, 64'd0, 0, 0, 0},
            '{0, 0, 0, 32'd0, 64'd10, 1, 0, 0},             // Fibonacci at reset config
            '{1, 7, 1, 32'hffff_ffff, 64'd0, 1, 1, 1},      // exponent zero: identity
            '{0, 0, 0, 32'h7fff_ffff, 64'd1, 1, 1, 1},
            '{0, 0, 0, 32'h8000_0000, 64'd1, 1, 1, 5},
            '{1, 0, 0, 32'd5, 64'd3, 1, 1, 0},              // modulus 0 acts as 1, dim 0 as 1
            '{0, 0, 0, 32'd5, 64'd0, 1, 1, 0},
            '{1, 32'h7fff_ffff, 1, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 1, 0, 0},
            '{0, 0, 0, 32'd2, 64'd31, 1, 1, 1},
            '{1, 1000, 2, 32'h7fff_ffff, 64'd0, 0, 0, 0},
            '{0, 0, 0, 32'h8000_0000, 64'd0, 0, 0, 0},
            '{0, 0, 0, 32'd3, 64'd0, 0, 0, 0},
            '{0, 0, 0, -32'sd5, 64'd0, 0, 0, 0},
            '{0, 0, 0, 32'd99, 64'd0, 0, 0, 0},             // overflow element, dropped
            '{0, 0, 0, 32'd77, 64'h8000_0000_0000_0001, 1, 0, 0},
            '{0, 0, 0, 32'd4, 64'd0, 0, 0, 0},
            '{0, 0, 0, 32'd6, 64'd0, 0, 0, 0},
            '{0, 0, 0, 32'd9, 64'd5, 1, 0, 0}               // early last: cell 3 kept
        };

        foreach (loaded[i]) loaded[i] = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            if (plan[r].setcfg) set_config(MOD_W'(plan[r].modv), MOD_W'(plan[r].dimv));
            send_elem(plan[r].elem, plan[r].expo, plan[r].last, 1'b0, ign);
            if (plan[r].chk && entries_due[$].entry != plan[r].want) begin
                errors++;
                if (errors <= 10)
                    $display("row %0d: predicted %0d, table says %0d",
                             r, entries_due[$].entry, plan[r].want);
            end
        end

        counted = 0;
        phase = 0;
        big_done = 1'b0;
        while (counted < 85) begin
            case ($urandom_range(0, 4))
                0: modv = '0;
                1: modv = 31'h7fff_ffff;
                2: modv = MOD_W'($urandom_range(1, 20));
                default: modv = MOD_W'($urandom());
            endcase
            if (phase >= 1 && !big_done) begin
                dimv = MOD_W'($urandom_range(8, 15));
                big_done = 1'b1;
            end else if ($urandom_range(0, 7) == 0) begin
                dimv = '0;
            end else begin
                dimv = MOD_W'($urandom_range(1, 4));
            end
            set_config(modv, dimv);
            n = eff_dim();
            total = n * n;
            calm = (phase == 0);
            reps = (n == MAX_DIM) ? 1 : int'($urandom_range(1, 3));
            repeat (reps) begin
                case ($urandom_range(0, 3))
                    0: ex = '0;
                    1: ex = 64'($urandom_range(1, 8));
                    2: ex = 64'd1 << $urandom_range(0, 63);
                    default: ex = {$urandom(), $urandom()};
                endcase
                if (n == MAX_DIM) ex = 64'($urandom_range(0, 300));
                kind = $urandom_range(0, 9);
                cut = total;
                if (kind == 1 && total > 1) begin
                    cut = $urandom_range(1, total - 1);
                    ok = 1'b1;
                    for (int i = cut; i < total; i++) ok &= loaded[i];
                    if (!ok) cut = total;
                end
                if (kind == 0) cut = total + $urandom_range(1, 3);
                for (int i = 0; i < cut; i++) begin
                    send_elem(pick_elem(), (i == cut - 1) ? ex : {$urandom(), $urandom()},
                              i == cut - 1, calm, ign);
                    if (!ign) counted++;
                end
                // at random, let the whole result matrix drain before the next load
                if ($urandom_range(0, 3) == 0) begin
                    start <= 1'b0;
                    while (entries_due.size() != 0) @(posedge i_clk);
                    @(posedge i_clk);
                end
            end
            phase++;
        end
        start <= 1'b0;
        wait_drained();

        if (errors == 0 && entries_due.size() == 0) begin
            $display("modular_matrix_power_core regression: pass");
        end else begin
            $display("modular_matrix_power_core regression: fail");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("modular_matrix_power_core regression: fail");
        $finish;
    end
endmodule
